@@ rtl/rpv_pkg.sv @@
// Shared types and constants for the vertex rotate and project pipeline.
package rpv_pkg;

   localparam int CFG_W      = 16;
   localparam int CTR_W      = 8;
   localparam int CORNER_W   = 3;
   localparam int SCR_W      = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int PROJ_SCALE = 78;
   localparam int QUO_W      = 10;
   localparam int DIV_STEP   = 2;
   localparam int DIV_STAGES = QUO_W / DIV_STEP;
   localparam int OUT_MIN    = -512;
   localparam int OUT_MAX    = 511;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIN_X    = 3'd0,
      CSR_COS_X    = 3'd1,
      CSR_SIN_Y    = 3'd2,
      CSR_COS_Y    = 3'd3,
      CSR_SIN_Z    = 3'd4,
      CSR_COS_Z    = 3'd5,
      CSR_CENTER_X = 3'd6,
      CSR_CENTER_Y = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [CFG_W-1:0] sin_x;
      logic signed [CFG_W-1:0] cos_x;
      logic signed [CFG_W-1:0] sin_y;
      logic signed [CFG_W-1:0] cos_y;
      logic signed [CFG_W-1:0] sin_z;
      logic signed [CFG_W-1:0] cos_z;
   } trig_type;

   typedef struct packed {
      logic valid;
      logic neg_x;
      logic neg_y;
      logic ovf_x;
      logic ovf_y;
   } div_ctl_type;

endpackage

@@ rtl/rpv_rotate.sv @@
// Three-stage rotation about X, Y and Z with depth offset and clamp.
module rpv_rotate import rpv_pkg::*; #(
   parameter int FRAC_BITS = 14,
   parameter int XW        = 21,
   parameter int X3W       = 24,
   parameter int DW        = 21
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [CORNER_W-1:0]   corner,
   input  trig_type              trig,
   output logic                  out_valid,
   output logic signed [X3W-1:0] x3,
   output logic signed [X3W-1:0] y3,
   output logic [DW-1:0]         depth
);

   localparam int R1W = CFG_W + 2;
   localparam int DSW = DW + 1;
   localparam longint DEPTH_Q = ((64'd34 << FRAC_BITS) + 64'd5) / 64'd10;

   logic sx, sy, sz;
   logic signed [R1W-1:0] y1_in, z1_in;
   logic v1_ff, sx1_ff;
   logic signed [R1W-1:0] y1_ff, z1_ff;

   logic signed [R1W+CFG_W-1:0] pzs, pzc;
   logic signed [XW-1:0] x2_in, z2_in;
   logic v2_ff;
   logic signed [XW-1:0] x2_ff, z2_ff;
   logic signed [R1W-1:0] y1b_ff;

   logic signed [XW+CFG_W-1:0] pxc, pxs;
   logic signed [R1W+CFG_W-1:0] pys, pyc;
   logic signed [X3W-1:0] x3_in, y3_in;
   logic signed [DSW-1:0] dsum;
   logic [DW-1:0] depth_in;
   logic v3_ff;
   logic signed [X3W-1:0] x3_ff, y3_ff;
   logic [DW-1:0] depth_ff;

   always_comb begin
      sx = corner[0] ^ corner[1];
      sy = corner[1];
      sz = corner[2];
      y1_in = (sy ? R1W'(trig.cos_x) : -R1W'(trig.cos_x))
            - (sz ? R1W'(trig.sin_x) : -R1W'(trig.sin_x));
      z1_in = (sy ? R1W'(trig.sin_x) : -R1W'(trig.sin_x))
            + (sz ? R1W'(trig.cos_x) : -R1W'(trig.cos_x));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      sx1_ff <= sx;
      y1_ff  <= y1_in;
      z1_ff  <= z1_in;
   end

   always_comb begin
      pzs   = z1_ff * trig.sin_y;
      pzc   = z1_ff * trig.cos_y;
      x2_in = (sx1_ff ? XW'(trig.cos_y) : -XW'(trig.cos_y)) + XW'(pzs >>> FRAC_BITS);
      z2_in = (sx1_ff ? -XW'(trig.sin_y) : XW'(trig.sin_y)) + XW'(pzc >>> FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      x2_ff  <= x2_in;
      z2_ff  <= z2_in;
      y1b_ff <= y1_ff;
   end

   always_comb begin
      pxc   = x2_ff * trig.cos_z;
      pxs   = x2_ff * trig.sin_z;
      pys   = y1b_ff * trig.sin_z;
      pyc   = y1b_ff * trig.cos_z;
      x3_in = X3W'(pxc >>> FRAC_BITS) - X3W'(pys >>> FRAC_BITS);
      y3_in = X3W'(pxs >>> FRAC_BITS) + X3W'(pyc >>> FRAC_BITS);
      dsum  = DSW'(DEPTH_Q) + DSW'(z2_ff);
      if (dsum < DSW'(1)) begin
         depth_in = DW'(1);
      end else begin
         depth_in = DW'(dsum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      x3_ff    <= x3_in;
      y3_ff    <= y3_in;
      depth_ff <= depth_in;
   end

   assign out_valid = v3_ff;
   assign x3        = x3_ff;
   assign y3        = y3_ff;
   assign depth     = depth_ff;

endmodule

@@ rtl/rpv_divide.sv @@
// Scale by the projection factor and pipelined restoring division, two lanes.
module rpv_divide import rpv_pkg::*; #(
   parameter int X3W = 24,
   parameter int DW  = 21
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic signed [X3W-1:0] x3,
   input  logic signed [X3W-1:0] y3,
   input  logic [DW-1:0]         depth,
   output div_ctl_type           ctl_out,
   output logic [QUO_W-1:0]      quo_x,
   output logic [QUO_W-1:0]      quo_y
);

   localparam int MW = X3W + 8;
   localparam int RW = ((MW > DW + QUO_W) ? MW : DW + QUO_W) + 1;

   logic signed [MW-1:0] nx, ny;
   logic [MW-1:0] ax, ay;
   logic [RW-1:0] dlim;
   div_ctl_type ctl_in;

   div_ctl_type      ctl_ff [DIV_STAGES+1];
   logic [RW-1:0]    remx_ff [DIV_STAGES+1];
   logic [RW-1:0]    remy_ff [DIV_STAGES+1];
   logic [DW-1:0]    den_ff [DIV_STAGES+1];
   logic [QUO_W-1:0] qx_ff [DIV_STAGES+1];
   logic [QUO_W-1:0] qy_ff [DIV_STAGES+1];

   always_comb begin
      nx   = MW'(x3) * MW'(PROJ_SCALE);
      ny   = MW'(y3) * MW'(PROJ_SCALE);
      ax   = nx[MW-1] ? MW'(-nx) : MW'(nx);
      ay   = ny[MW-1] ? MW'(-ny) : MW'(ny);
      dlim = RW'(depth) << QUO_W;
      ctl_in.valid = in_valid;
      ctl_in.neg_x = nx[MW-1];
      ctl_in.neg_y = ny[MW-1];
      ctl_in.ovf_x = RW'(ax) >= dlim;
      ctl_in.ovf_y = RW'(ay) >= dlim;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else begin
         ctl_ff[0] <= ctl_in;
      end
      remx_ff[0] <= RW'(ax);
      remy_ff[0] <= RW'(ay);
      den_ff[0]  <= depth;
      qx_ff[0]   <= '0;
      qy_ff[0]   <= '0;
   end

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic [RW-1:0]    rx, ry, dsh;
      logic [QUO_W-1:0] qx, qy;

      always_comb begin
         rx = remx_ff[s];
         ry = remy_ff[s];
         qx = qx_ff[s];
         qy = qy_ff[s];
         for (int k = 0; k < DIV_STEP; k++) begin
            dsh = RW'(den_ff[s]) << (QUO_W - 1 - s * DIV_STEP - k);
            qx  = qx << 1;
            qy  = qy << 1;
            if (rx >= dsh) begin
               rx    = rx - dsh;
               qx[0] = 1'b1;
            end
            if (ry >= dsh) begin
               ry    = ry - dsh;
               qy[0] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s+1] <= '0;
         end else begin
            ctl_ff[s+1] <= ctl_ff[s];
         end
         remx_ff[s+1] <= rx;
         remy_ff[s+1] <= ry;
         den_ff[s+1]  <= den_ff[s];
         qx_ff[s+1]   <= qx;
         qy_ff[s+1]   <= qy;
      end
   end

   assign ctl_out = ctl_ff[DIV_STAGES];
   assign quo_x   = qx_ff[DIV_STAGES];
   assign quo_y   = qy_ff[DIV_STAGES];

endmodule

@@ rtl/rotate_project_vertex.sv @@
// Top level: cube corner rotate and perspective project pipeline.
// From start to rsp_strobe an item passes the rotate, scale, divide and output registers in that order.
// Throughput: one item per cycle; busy stays low, so start may be high every cycle.
// The divider retires two quotient bits per stage, which sets the pipeline depth.
// Reset clears all valid bits and loads the default angles and screen center.
// Results cannot be stalled; each shows on rsp_strobe for one cycle.
module rotate_project_vertex import rpv_pkg::*; #(
   parameter int FRAC_BITS = 14
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [CORNER_W-1:0]         req_corner,
   output logic                        rsp_strobe,
   output logic signed [SCR_W-1:0]     rsp_screen_x,
   output logic signed [SCR_W-1:0]     rsp_screen_y,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CFG_W-1:0]            csr_data
);

   localparam int XW  = ((34 - FRAC_BITS > 17) ? 34 - FRAC_BITS : 17) + 1;
   localparam int X3W = (((XW + CFG_W - FRAC_BITS) > (34 - FRAC_BITS)) ?
                         (XW + CFG_W - FRAC_BITS) : (34 - FRAC_BITS)) + 1;
   localparam int DW  = ((XW > FRAC_BITS + 3) ? XW : FRAC_BITS + 3);
   localparam int LAT = 3 + 1 + DIV_STAGES + 1;
   localparam int SW  = 12;

   trig_type         trig_ff;
   logic [CTR_W-1:0] center_x_ff, center_y_ff;

   logic                  rot_valid;
   logic signed [X3W-1:0] x3, y3;
   logic [DW-1:0]         depth;
   div_ctl_type           dctl;
   logic [QUO_W-1:0]      quo_x, quo_y;

   logic signed [SW-1:0]    qxs, qys, vx, vy;
   logic signed [SCR_W-1:0] sx_in, sy_in;
   logic                    strobe_ff;
   logic signed [SCR_W-1:0] sx_ff, sy_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ff.sin_x <= 16'sd5618;
         trig_ff.cos_x <= 16'sd15391;
         trig_ff.sin_y <= 16'sd9916;
         trig_ff.cos_y <= 16'sd13044;
         trig_ff.sin_z <= 16'sd1961;
         trig_ff.cos_z <= 16'sd16266;
         center_x_ff   <= 8'd120;
         center_y_ff   <= 8'd69;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_SIN_X:    trig_ff.sin_x <= csr_data;
            CSR_COS_X:    trig_ff.cos_x <= csr_data;
            CSR_SIN_Y:    trig_ff.sin_y <= csr_data;
            CSR_COS_Y:    trig_ff.cos_y <= csr_data;
            CSR_SIN_Z:    trig_ff.sin_z <= csr_data;
            CSR_COS_Z:    trig_ff.cos_z <= csr_data;
            CSR_CENTER_X: center_x_ff   <= csr_data[CTR_W-1:0];
            CSR_CENTER_Y: center_y_ff   <= csr_data[CTR_W-1:0];
            default:      center_y_ff   <= center_y_ff;
         endcase
      end
   end

   rpv_rotate #(
      .FRAC_BITS (FRAC_BITS),
      .XW        (XW),
      .X3W       (X3W),
      .DW        (DW)
   ) u_rotate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .corner    (req_corner),
      .trig      (trig_ff),
      .out_valid (rot_valid),
      .x3        (x3),
      .y3        (y3),
      .depth     (depth)
   );

   rpv_divide #(
      .X3W (X3W),
      .DW  (DW)
   ) u_divide (
      .clock    (clock),
      .reset    (reset),
      .in_valid (rot_valid),
      .x3       (x3),
      .y3       (y3),
      .depth    (depth),
      .ctl_out  (dctl),
      .quo_x    (quo_x),
      .quo_y    (quo_y)
   );

   always_comb begin
      qxs = dctl.neg_x ? -SW'(quo_x) : SW'(quo_x);
      qys = dctl.neg_y ? -SW'(quo_y) : SW'(quo_y);
      vx  = SW'(center_x_ff) + qxs;
      vy  = SW'(center_y_ff) + qys;
      if (dctl.ovf_x) begin
         sx_in = dctl.neg_x ? SCR_W'(OUT_MIN) : SCR_W'(OUT_MAX);
      end else if (vx < SW'(OUT_MIN)) begin
         sx_in = SCR_W'(OUT_MIN);
      end else if (vx > SW'(OUT_MAX)) begin
         sx_in = SCR_W'(OUT_MAX);
      end else begin
         sx_in = SCR_W'(vx);
      end
      if (dctl.ovf_y) begin
         sy_in = dctl.neg_y ? SCR_W'(OUT_MIN) : SCR_W'(OUT_MAX);
      end else if (vy < SW'(OUT_MIN)) begin
         sy_in = SCR_W'(OUT_MIN);
      end else if (vy > SW'(OUT_MAX)) begin
         sy_in = SCR_W'(OUT_MAX);
      end else begin
         sy_in = SCR_W'(vy);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= dctl.valid;
      end
      sx_ff <= sx_in;
      sy_ff <= sy_in;
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_screen_x = sx_ff;
   assign rsp_screen_y = sy_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##LAT rsp_strobe)
      else $error("item did not emerge after pipeline latency");

   a_ovf_x: assert property (@(posedge clock) disable iff (reset)
      dctl.valid && dctl.ovf_x |=>
         rsp_screen_x == SCR_W'(OUT_MIN) || rsp_screen_x == SCR_W'(OUT_MAX))
      else $error("x overflow not saturated");

   a_ovf_y: assert property (@(posedge clock) disable iff (reset)
      dctl.valid && dctl.ovf_y |=>
         rsp_screen_y == SCR_W'(OUT_MIN) || rsp_screen_y == SCR_W'(OUT_MAX))
      else $error("y overflow not saturated");

endmodule
